// ----- sv/bafc_pkg.sv -----
// Shared types, constants and helper functions of the anisotropy field cell.
package bafc_pkg;

	localparam int unsigned MAX_CELLS = 16777216;
	localparam int unsigned CNT_W     = 25;

	// 2/mu0 scaled by 2^8, rounded
	localparam logic [28:0] GAIN = 29'd407436654;

	// 1.0 in Q60, the unit term of the uniaxial energy
	localparam logic signed [65:0] E_ONE = 66'sd1152921504606846976;

	localparam int unsigned DIV_STEPS = 64;
	localparam int unsigned DIV_CNT_W = 7;

	typedef enum logic [2:0] {
		REG_MESH_MODE,
		REG_SAT_MAG,
		REG_ANIS_A,
		REG_ANIS_B,
		REG_AXIS_ONE,
		REG_AXIS_TWO,
		REG_AXIS_THREE
	} cfg_reg_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_LANE,
		T_MERGE
	} top_state_t;

	typedef enum logic [2:0] {
		LN_IDLE,
		LN_DOT,
		LN_ABS,
		LN_DIV_P,
		LN_MUL,
		LN_FLD,
		LN_DIV_F
	} lane_state_t;

	typedef enum logic [3:0] {
		MS_C1,
		MS_P,
		MS_UU,
		MS_S2,
		MS_S3,
		MS_C2,
		MS_C3,
		MS_EW,
		MS_PP,
		MS_EQ
	} mul_step_t;

	typedef enum logic [2:0] {
		FS_T1,
		FS_T2,
		FS_T3,
		FS_ABS,
		FS_G1,
		FS_G2
	} fld_step_t;

	typedef enum logic [1:0] {
		MG_IDLE,
		MG_ACC,
		MG_DIV_GO,
		MG_DIV
	} merge_state_t;

	typedef struct packed {
		logic [31:0]        ms;
		logic signed [31:0] k1;
		logic signed [31:0] k2;
	} lane_cfg_t;

	typedef struct packed {
		logic [2:0][31:0]   h;
		logic signed [56:0] eq;
	} lane_res_t;

	typedef struct packed {
		logic signed [33:0] energy_a;
		logic signed [33:0] energy_b;
		logic signed [33:0] mean;
	} merge_res_t;

	// Signed shift right that rounds toward zero
	function automatic logic signed [65:0] trunc_shift(input logic signed [65:0] v,
			input int unsigned sh);
		logic signed [65:0] bias;
		bias = v[65] ? ((66'sd1 <<< sh) - 66'sd1) : 66'sd0;
		return (v + bias) >>> sh;
	endfunction

	function automatic logic signed [33:0] sat34(input logic signed [65:0] v);
		if (v > 66'sd8589934591) begin
			return 34'sh1FFFFFFFF;
		end else if (v < -66'sd8589934592) begin
			return 34'sh200000000;
		end
		return v[33:0];
	endfunction

endpackage

// ----- sv/bafc_div.sv -----
// Restoring divider: 64-bit unsigned numerator by 32-bit divisor, one bit per cycle.
module bafc_div import bafc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic        busy,
	output logic [63:0] quo
);

	logic [31:0]          rem_q;
	logic [63:0]          quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [32:0]          trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[63]};
	assign fits  = trial >= {1'b0, den};
	assign busy  = cnt_q != '0;
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(DIV_STEPS);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (busy) begin
			rem_q <= fits ? 32'(trial - {1'b0, den}) : trial[31:0];
			quo_q <= {quo_q[62:0], fits};
		end
	end

endmodule

// ----- sv/bafc_lane.sv -----
// One sublattice lane: projections, anisotropy coefficients, field and energy.
module bafc_lane import bafc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2:0][23:0]      mag,
	input  lane_cfg_t             cfg,
	input  logic [2:0][2:0][15:0] axes,
	output logic                  busy,
	output lane_res_t             res
);

	lane_state_t state_q, state_d;
	logic [1:0]  dot_idx_q;
	mul_step_t   mstep_q;
	fld_step_t   fstep_q;
	logic        div_go_q;

	logic signed [41:0] dot_q [3];
	logic [63:0]        num_q [3];
	logic [2:0]         neg_q;
	logic signed [31:0] proj_q [3];
	logic signed [43:0] c1_q;
	logic signed [33:0] p_q;
	logic signed [23:0] w_q;
	logic signed [24:0] s2_q;
	logic signed [24:0] s3_q;
	logic signed [45:0] c2_q;
	logic signed [45:0] c3_q;
	logic signed [26:0] q_q;
	logic signed [56:0] eq_q;
	logic signed [62:0] acc_q [3];
	logic [59:0]        gp_q [3];
	lane_res_t          res_q;

	logic [2:0]         div_busy;
	logic [63:0]        div_quo [3];
	logic               div_done;
	logic               ms_zero;

	logic signed [41:0] dot_s;
	logic signed [39:0] dprod [3];
	logic signed [33:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [65:0] prod;
	logic signed [65:0] pp_full;
	logic signed [23:0] pp;
	logic [1:0]         row;
	logic signed [46:0] coef;
	logic signed [62:0] term [3];
	logic [59:0]        gh [3];

	assign div_done = !div_go_q && (div_busy == '0);
	assign ms_zero  = cfg.ms == '0;
	assign busy     = state_q != LN_IDLE;
	assign res      = res_q;

	for (genvar g = 0; g < 3; g++) begin : g_div
		bafc_div u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (div_go_q),
			.num    (num_q[g]),
			.den    (cfg.ms),
			.busy   (div_busy[g]),
			.quo    (div_quo[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LN_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			LN_IDLE:  if (start) state_d = LN_DOT;
			LN_DOT:   if (dot_idx_q == 2'd2) state_d = LN_ABS;
			LN_ABS:   state_d = LN_DIV_P;
			LN_DIV_P: if (div_done) state_d = LN_MUL;
			LN_MUL:   if (mstep_q == MS_EQ) state_d = LN_FLD;
			LN_FLD:   if (fstep_q == FS_G2) state_d = LN_DIV_F;
			LN_DIV_F: if (div_done) state_d = LN_IDLE;
			default:  state_d = LN_IDLE;
		endcase
	end

	// step counters and divider start pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_idx_q <= '0;
			mstep_q   <= MS_C1;
			fstep_q   <= FS_T1;
			div_go_q  <= 1'b0;
		end else begin
			dot_idx_q <= (state_q == LN_DOT) ? dot_idx_q + 2'd1 : 2'd0;
			mstep_q   <= (state_q == LN_MUL) ? mul_step_t'(mstep_q + 4'd1) : MS_C1;
			fstep_q   <= (state_q == LN_FLD) ? fld_step_t'(fstep_q + 3'd1) : FS_T1;
			div_go_q  <= (state_q == LN_ABS) || (state_q == LN_FLD && fstep_q == FS_G2);
		end
	end

	// one projection row per cycle
	always_comb begin
		dot_s = '0;
		for (int k = 0; k < 3; k++) begin
			dprod[k] = $signed(mag[k]) * $signed(axes[dot_idx_q][k]);
			dot_s    = dot_s + 42'(dprod[k]);
		end
	end

	// shared coefficient multiplier
	assign pp_full = trunc_shift(66'(p_q), 10);
	assign pp      = pp_full[23:0];

	always_comb begin
		unique case (mstep_q)
			MS_C1:   begin mul_a = 34'(cfg.k1);      mul_b = proj_q[0]; end
			MS_P:    begin mul_a = 34'(proj_q[1]);   mul_b = proj_q[2]; end
			MS_UU:   begin mul_a = 34'(proj_q[0]);   mul_b = proj_q[0]; end
			MS_S2:   begin mul_a = p_q;              mul_b = proj_q[2]; end
			MS_S3:   begin mul_a = p_q;              mul_b = proj_q[1]; end
			MS_C2:   begin mul_a = 34'(s2_q);        mul_b = cfg.k2;    end
			MS_C3:   begin mul_a = 34'(s3_q);        mul_b = cfg.k2;    end
			MS_EW:   begin mul_a = 34'(w_q);         mul_b = cfg.k1;    end
			MS_PP:   begin mul_a = 34'(pp);          mul_b = 32'(pp);   end
			MS_EQ:   begin mul_a = 34'(q_q);         mul_b = cfg.k2;    end
			default: begin mul_a = '0;               mul_b = '0;        end
		endcase
		prod = mul_a * mul_b;
	end

	// field terms, one per component
	always_comb begin
		case (fstep_q)
			FS_T2:   begin row = 2'd1; coef = 47'(c2_q); end
			FS_T3:   begin row = 2'd2; coef = 47'(c3_q); end
			default: begin row = 2'd0; coef = 47'(c1_q); end
		endcase
		for (int i = 0; i < 3; i++) begin
			term[i] = coef * $signed(axes[row][i]);
			gh[i]   = acc_q[i][61:31] * GAIN;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			LN_DOT: begin
				dot_q[dot_idx_q] <= dot_s;
			end
			LN_ABS: begin
				for (int j = 0; j < 3; j++) begin
					neg_q[j] <= dot_q[j][41];
					num_q[j] <= {6'b0, (dot_q[j][41] ? -dot_q[j] : dot_q[j]), 16'b0};
				end
			end
			LN_DIV_P: begin
				if (div_done) begin
					for (int j = 0; j < 3; j++) begin
						logic [30:0] m31;
						m31 = (div_quo[j][63:31] != '0) ? 31'h7FFFFFFF : div_quo[j][30:0];
						if (ms_zero) begin
							proj_q[j] <= '0;
						end else begin
							proj_q[j] <= neg_q[j] ? -$signed({1'b0, m31}) : $signed({1'b0, m31});
						end
					end
				end
			end
			LN_MUL: begin
				case (mstep_q)
					MS_C1: c1_q <= 44'(trunc_shift(prod, 20));
					MS_P:  p_q  <= 34'(trunc_shift(prod, 30));
					MS_UU: w_q  <= 24'(trunc_shift(E_ONE - prod, 40));
					MS_S2: s2_q <= 25'(trunc_shift(prod, 40));
					MS_S3: s3_q <= 25'(trunc_shift(prod, 40));
					MS_C2: c2_q <= 46'(trunc_shift(prod, 10));
					MS_C3: c3_q <= 46'(trunc_shift(prod, 10));
					MS_EW: eq_q <= prod[56:0];
					MS_PP: q_q  <= 27'(prod >>> 20);
					MS_EQ: eq_q <= eq_q + prod[56:0];
					default: ;
				endcase
			end
			LN_FLD: begin
				for (int i = 0; i < 3; i++) begin
					case (fstep_q)
						FS_T1:  acc_q[i] <= term[i];
						FS_T2:  acc_q[i] <= acc_q[i] - term[i];
						FS_T3:  acc_q[i] <= acc_q[i] - term[i];
						FS_ABS: begin
							neg_q[i] <= acc_q[i][62];
							acc_q[i] <= acc_q[i][62] ? -acc_q[i] : acc_q[i];
						end
						FS_G1:  gp_q[i] <= acc_q[i][30:0] * GAIN;
						FS_G2: begin
							logic [90:0] gsum;
							gsum     = (91'(gh[i]) << 31) + 91'(gp_q[i]);
							num_q[i] <= {5'b0, gsum[90:32]};
						end
						default: ;
					endcase
				end
			end
			LN_DIV_F: begin
				if (div_done) begin
					res_q.eq <= eq_q;
					for (int j = 0; j < 3; j++) begin
						logic [31:0] mg;
						if (neg_q[j]) begin
							mg = ((div_quo[j][63:32] != '0) ||
								(div_quo[j][31] && (div_quo[j][30:0] != '0))) ?
								32'h80000000 : div_quo[j][31:0];
							res_q.h[j] <= ms_zero ? 32'd0 : -mg;
						end else begin
							mg = (div_quo[j][63:31] != '0) ? 32'h7FFFFFFF
								: {1'b0, div_quo[j][30:0]};
							res_q.h[j] <= ms_zero ? 32'd0 : mg;
						end
					end
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- sv/bafc_merge.sv -----
// Merging stage: energy outputs, sweep accumulators and the mean energy.
module bafc_merge import bafc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               afm,
	input  logic               empty,
	input  logic               last,
	input  logic signed [56:0] ea,
	input  logic signed [56:0] eb,
	output logic               busy,
	output merge_res_t         res
);

	merge_state_t state_q, state_d;

	logic signed [63:0]  total_q;
	logic [CNT_W-1:0]    count_q;
	logic signed [38:0]  cell_q;
	logic                take_q;
	logic                last_q;
	merge_res_t          res_q;

	logic                div_start;
	logic                div_busy;
	logic [63:0]         div_quo;
	logic [63:0]         total_mag;
	logic signed [64:0]  sum;
	logic signed [38:0]  cell_d;

	assign busy      = state_q != MG_IDLE;
	assign res       = res_q;
	assign total_mag = total_q[63] ? 64'(-total_q) : 64'(total_q);
	assign div_start = (state_q == MG_DIV_GO) && (count_q != '0);
	assign sum       = 65'(total_q) + 65'(cell_q);
	assign cell_d    = afm ? 39'(trunc_shift(66'(ea) + 66'(eb), 21))
		: 39'(trunc_shift(66'(ea), 20));

	bafc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (total_mag),
		.den    (32'(count_q)),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MG_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			MG_IDLE:   if (start) state_d = MG_ACC;
			MG_ACC:    state_d = last_q ? MG_DIV_GO : MG_IDLE;
			MG_DIV_GO: state_d = (count_q != '0) ? MG_DIV : MG_IDLE;
			MG_DIV:    if (!div_busy) state_d = MG_IDLE;
			default:   state_d = MG_IDLE;
		endcase
	end

	// sweep accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				MG_ACC: begin
					if (take_q) begin
						if (sum > 65'(64'sh7FFFFFFFFFFFFFFF)) begin
							total_q <= 64'sh7FFFFFFFFFFFFFFF;
						end else if (sum < 65'(64'sh8000000000000000)) begin
							total_q <= 64'sh8000000000000000;
						end else begin
							total_q <= sum[63:0];
						end
						if (count_q < CNT_W'(MAX_CELLS)) count_q <= count_q + 1'b1;
					end
				end
				MG_DIV_GO: begin
					if (count_q == '0) total_q <= '0;
				end
				MG_DIV: begin
					if (!div_busy) begin
						total_q <= '0;
						count_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == MG_IDLE && start) begin
			res_q.energy_a <= sat34(trunc_shift(66'(ea), 20));
			res_q.energy_b <= sat34(trunc_shift(66'(eb), 20));
			res_q.mean     <= '0;
			cell_q         <= cell_d;
			take_q         <= !empty;
			last_q         <= last;
		end else if (state_q == MG_DIV && !div_busy) begin
			if (total_q[63]) begin
				res_q.mean <= (div_quo > 64'd8589934592) ? 34'sh200000000
					: -$signed(div_quo[33:0]);
			end else begin
				res_q.mean <= (div_quo > 64'd8589934591) ? 34'sh1FFFFFFFF
					: $signed(div_quo[33:0]);
			end
		end
	end

endmodule

// ----- sv/biaxial_anisotropy_field_cell.sv -----
// Top level of the anisotropy field cell: registers, lanes, merge and output register.
//
// Computes the uniaxial plus biaxial anisotropy field and energy density of one
// mesh cell per item. One lane per sublattice (A always, B in antiferromagnetic
// mode) runs side by side; the run of each lane is set by two passes
// of its bit-serial 64-step dividers (projections, then field scaling by Ms),
// a ten-step shared coefficient multiplier and a six-step field sequence. The
// merging stage follows, and on a last cell with filled cells in its sweep a
// further division for the mean energy. An empty cell skips the lanes.
// One item is in work at a time; the finished result waits in an output
// register, so the next item can be taken while it is still held by out_stall.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// must only change while the block is idle.
module biaxial_anisotropy_field_cell import bafc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] mag_a_x,
	input  logic signed [23:0] mag_a_y,
	input  logic signed [23:0] mag_a_z,
	input  logic signed [23:0] mag_b_x,
	input  logic signed [23:0] mag_b_y,
	input  logic signed [23:0] mag_b_z,
	input  logic               cell_empty,
	input  logic               last_cell,

	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] field_a_x,
	output logic signed [31:0] field_a_y,
	output logic signed [31:0] field_a_z,
	output logic signed [31:0] field_b_x,
	output logic signed [31:0] field_b_y,
	output logic signed [31:0] field_b_z,
	output logic signed [33:0] energy_a,
	output logic signed [33:0] energy_b,
	output logic signed [33:0] mean_energy,
	output logic               sweep_done
);

	// configuration registers
	logic        mode_q;
	logic [63:0] ms_pair_q;
	logic [63:0] anis_a_q;
	logic [63:0] anis_b_q;
	logic [47:0] axis_one_q;
	logic [47:0] axis_two_q;
	logic [47:0] axis_three_q;

	top_state_t state_q, state_d;
	logic       go_q;
	logic       out_valid_q;

	// captured item
	logic [2:0][23:0] mag_a_q;
	logic [2:0][23:0] mag_b_q;
	logic             empty_q;
	logic             last_q;
	logic             use_a_q;
	logic             use_b_q;

	logic accept;
	logic merge_start;
	logic load_out;
	logic busy_a, busy_b, merge_busy;

	logic [2:0][2:0][15:0] axes;
	lane_cfg_t             cfg_a, cfg_b;
	lane_res_t             res_a, res_b;
	merge_res_t            mres;
	logic signed [56:0]    ea, eb;

	assign axes = {axis_three_q, axis_two_q, axis_one_q};
	assign cfg_a = '{ms: ms_pair_q[31:0],  k1: anis_a_q[31:0], k2: anis_a_q[63:32]};
	assign cfg_b = '{ms: ms_pair_q[63:32], k1: anis_b_q[31:0], k2: anis_b_q[63:32]};

	// a lane that did not run reports zero
	assign ea = use_a_q ? res_a.eq : '0;
	assign eb = use_b_q ? res_b.eq : '0;

	// configuration writes; an index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b0;
			ms_pair_q    <= 64'd3435973837600000;
			anis_a_q     <= '0;
			anis_b_q     <= '0;
			axis_one_q   <= 48'd16384;
			axis_two_q   <= 48'd1073741824;
			axis_three_q <= 48'd70368744177664;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MESH_MODE:  mode_q       <= cfg_data[0];
				REG_SAT_MAG:    ms_pair_q    <= cfg_data;
				REG_ANIS_A:     anis_a_q     <= cfg_data;
				REG_ANIS_B:     anis_b_q     <= cfg_data;
				REG_AXIS_ONE:   axis_one_q   <= cfg_data[47:0];
				REG_AXIS_TWO:   axis_two_q   <= cfg_data[47:0];
				REG_AXIS_THREE: axis_three_q <= cfg_data[47:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: take an item, run the lanes, merge, then hand over the result
	always_comb begin
		state_d     = state_q;
		in_stall    = 1'b1;
		accept      = 1'b0;
		merge_start = 1'b0;
		load_out    = 1'b0;
		unique case (state_q)
			T_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					accept  = 1'b1;
					state_d = T_LANE;
				end
			end
			T_LANE: begin
				if (!go_q && !busy_a && !busy_b) begin
					merge_start = 1'b1;
					state_d     = T_MERGE;
				end
			end
			T_MERGE: begin
				// hold the result until the output register frees up
				if (!merge_busy && (!out_valid_q || !out_stall)) begin
					load_out = 1'b1;
					state_d  = T_IDLE;
				end
			end
			default: state_d = T_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			go_q <= accept;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_a_q <= {mag_a_z, mag_a_y, mag_a_x};
			mag_b_q <= {mag_b_z, mag_b_y, mag_b_x};
			empty_q <= cell_empty;
			last_q  <= last_cell;
			use_a_q <= !cell_empty;
			use_b_q <= !cell_empty && mode_q;
		end
	end

	bafc_lane u_lane_a (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go_q && use_a_q),
		.mag    (mag_a_q),
		.cfg    (cfg_a),
		.axes   (axes),
		.busy   (busy_a),
		.res    (res_a)
	);

	bafc_lane u_lane_b (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go_q && use_b_q),
		.mag    (mag_b_q),
		.cfg    (cfg_b),
		.axes   (axes),
		.busy   (busy_b),
		.res    (res_b)
	);

	bafc_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (merge_start),
		.afm    (use_b_q),
		.empty  (empty_q),
		.last   (last_q),
		.ea     (ea),
		.eb     (eb),
		.busy   (merge_busy),
		.res    (mres)
	);

	// output register
	always_ff @(posedge clk) begin
		if (load_out) begin
			field_a_x   <= use_a_q ? res_a.h[0] : 32'd0;
			field_a_y   <= use_a_q ? res_a.h[1] : 32'd0;
			field_a_z   <= use_a_q ? res_a.h[2] : 32'd0;
			field_b_x   <= use_b_q ? res_b.h[0] : 32'd0;
			field_b_y   <= use_b_q ? res_b.h[1] : 32'd0;
			field_b_z   <= use_b_q ? res_b.h[2] : 32'd0;
			energy_a    <= mres.energy_a;
			energy_b    <= mres.energy_b;
			mean_energy <= mres.mean;
			sweep_done  <= last_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- sim/tb_biaxial_anisotropy_field_cell.sv -----
// Self-checking testbench of the anisotropy field cell with a built-in predictor.
module tb_biaxial_anisotropy_field_cell;
	import bafc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  RUN_LIMIT  = 3000000; // cycles; the slowest correct run is well below
	localparam int  DRAIN_WAIT = 400;     // longer than one last cell through lanes and mean
	localparam int  LONG_HOLD  = 2500;    // receiver hold-off, in cycles
	localparam longint Q31_MAX = 64'sd2147483647;

	typedef longint vec3_t[3];

	typedef struct {
		logic signed [23:0] ma[3];
		logic signed [23:0] mb[3];
		logic               empty;
		logic               last;
	} cell_item_t;

	typedef struct {
		logic signed [31:0] ha[3];
		logic signed [31:0] hb[3];
		logic signed [33:0] ea;
		logic signed [33:0] eb;
		logic signed [33:0] mean;
		logic               done;
	} cell_result_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [63:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic signed [23:0] mag_a_x, mag_a_y, mag_a_z;
	logic signed [23:0] mag_b_x, mag_b_y, mag_b_z;
	logic               cell_empty;
	logic               last_cell;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] field_a_x, field_a_y, field_a_z;
	logic signed [31:0] field_b_x, field_b_y, field_b_z;
	logic signed [33:0] energy_a, energy_b, mean_energy;
	logic               sweep_done;

	biaxial_anisotropy_field_cell dut (.*);

	// Predictor copy of the registers and the sweep accumulators
	logic        cur_mode;
	logic [63:0] cur_ms_pair;
	logic [63:0] cur_k_a;
	logic [63:0] cur_k_b;
	logic [47:0] cur_axis[3];
	longint      energy_sum;
	longint      filled_cells;

	cell_item_t   pending_cells[$];
	cell_result_t expected_results[$];
	int           mismatch_count;
	int           results_seen;
	int           cycle_count;

	// Clock: 2 ns period, starts low so the first rising edge follows initialization
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic longint sat_to(longint v, int w);
		longint hi, lo;
		hi = (64'sd1 <<< (w - 1)) - 1;
		lo = -(64'sd1 <<< (w - 1));
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	// Normalized projection M.e/Ms in Q1.30, symmetric clamp
	function automatic longint proj_unit(vec3_t m, vec3_t e, longint unsigned ms);
		longint dot, u;
		if (ms == 0) return 0;
		dot = m[0] * e[0] + m[1] * e[1] + m[2] * e[2];
		u = (dot * 65536) / longint'(ms);
		if (u > Q31_MAX) u = Q31_MAX;
		if (u < -Q31_MAX) u = -Q31_MAX;
		return u;
	endfunction

	// |v| * GAIN / Ms / 2^32, sign restored, saturated to 32 bits
	function automatic longint scale_field(longint v, longint unsigned ms);
		longint unsigned mag, q, r, x, g;
		if (ms == 0) return 0;
		g = longint'(GAIN);
		mag = v < 0 ? longint'(-v) : longint'(v);
		q = mag / ms;
		r = mag % ms;
		if (q > (64'h8000_0000_0000_0000 / g)) x = 64'hFFFF_FFFF_FFFF_FFFF;
		else x = q * g + (r * g) / ms;
		x = x >> 32;
		if (v < 0) begin
			if (x > 64'h8000_0000) x = 64'h8000_0000;
			return -longint'(x);
		end
		if (x > 64'h7FFF_FFFF) x = 64'h7FFF_FFFF;
		return longint'(x);
	endfunction

	function automatic void anis_lane(vec3_t m, longint unsigned ms, logic [63:0] kpair,
			output vec3_t h, output longint eq);
		vec3_t  ax[3];
		longint k1, k2, u, b1, b2, c1, p, c2, c3, w, pp;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				ax[i][j] = longint'($signed(cur_axis[i][16*j +: 16]));
		k1 = longint'($signed(kpair[31:0]));
		k2 = longint'($signed(kpair[63:32]));
		u  = proj_unit(m, ax[0], ms);
		b1 = proj_unit(m, ax[1], ms);
		b2 = proj_unit(m, ax[2], ms);
		c1 = (k1 * u) / (64'sd1 <<< 20);
		p  = (b1 * b2) / (64'sd1 <<< 30);
		c2 = (k2 * ((p * b2) / (64'sd1 <<< 40))) / 1024;
		c3 = (k2 * ((p * b1) / (64'sd1 <<< 40))) / 1024;
		for (int i = 0; i < 3; i++)
			h[i] = scale_field(c1 * ax[0][i] - c2 * ax[1][i] - c3 * ax[2][i], ms);
		w  = ((64'sd1 <<< 60) - u * u) / (64'sd1 <<< 40);
		pp = p / 1024;
		eq = k1 * w + k2 * ((pp * pp) / (64'sd1 <<< 20));
	endfunction

	// Expected result of one cell; advances the sweep accumulators
	function automatic cell_result_t predict_cell(cell_item_t c);
		cell_result_t res;
		vec3_t  ma, mb, ha, hb;
		longint ea, eb, cell_e, mean;
		ha = '{0, 0, 0};
		hb = '{0, 0, 0};
		ea = 0;
		eb = 0;
		mean = 0;
		for (int i = 0; i < 3; i++) begin
			ma[i] = longint'(c.ma[i]);
			mb[i] = longint'(c.mb[i]);
		end
		if (!c.empty) begin
			anis_lane(ma, longint'(cur_ms_pair[31:0]), cur_k_a, ha, ea);
			if (cur_mode) begin
				anis_lane(mb, longint'(cur_ms_pair[63:32]), cur_k_b, hb, eb);
				cell_e = (ea + eb) / (64'sd1 <<< 21);
			end else begin
				cell_e = ea / (64'sd1 <<< 20);
			end
			if (cell_e > 0 && energy_sum > 64'sh7FFF_FFFF_FFFF_FFFF - cell_e)
				energy_sum = 64'sh7FFF_FFFF_FFFF_FFFF;
			else if (cell_e < 0 && energy_sum < 64'sh8000_0000_0000_0000 - cell_e)
				energy_sum = 64'sh8000_0000_0000_0000;
			else
				energy_sum += cell_e;
			if (filled_cells < MAX_CELLS) filled_cells++;
		end
		if (c.last) begin
			if (filled_cells != 0) mean = sat_to(energy_sum / filled_cells, 34);
			energy_sum = 0;
			filled_cells = 0;
		end
		for (int i = 0; i < 3; i++) begin
			res.ha[i] = ha[i][31:0];
			res.hb[i] = hb[i][31:0];
		end
		res.ea   = 34'(sat_to(ea / (64'sd1 <<< 20), 34));
		res.eb   = 34'(sat_to(eb / (64'sd1 <<< 20), 34));
		res.mean = mean[33:0];
		res.done = c.last;
		return res;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("[%0t] result %0d: %s got %0d, expected %0d", $realtime, results_seen,
			what, got, want);
		mismatch_count++;
	endtask

	// Driver: bursts of random length with random gaps in between
	int         burst_left;
	int         gap_left;
	cell_item_t cur_cell;

	always @(posedge clk) begin
		logic next_valid;
		next_valid = in_valid;
		if (in_valid && !in_stall) begin
			expected_results.push_back(predict_cell(cur_cell));
			next_valid = 1'b0;
		end
		if (!next_valid) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_cells.size() > 0) begin
				cur_cell = pending_cells.pop_front();
				next_valid = 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
				end
			end
		end
		in_valid   <= next_valid;
		mag_a_x    <= cur_cell.ma[0];
		mag_a_y    <= cur_cell.ma[1];
		mag_a_z    <= cur_cell.ma[2];
		mag_b_x    <= cur_cell.mb[0];
		mag_b_y    <= cur_cell.mb[1];
		mag_b_z    <= cur_cell.mb[2];
		cell_empty <= cur_cell.empty;
		last_cell  <= cur_cell.last;
	end

	// Receiver: one of four stall patterns, chosen at random and changed periodically, plus one long hold-off
	int  stall_kind;
	int  hold_left;
	bit  hold_done;

	always @(posedge clk) begin
		if (cycle_count % 64 == 0) stall_kind = $urandom_range(0, 3);
		if (!hold_done && results_seen >= 150) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (stall_kind)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= ($urandom_range(0, 1) == 0);
			endcase
		end
	end

	// Monitor: compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		cell_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$display("[%0t] unexpected result %0d", $realtime, results_seen);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				if (field_a_x !== want.ha[0]) report_mismatch("field_a_x", field_a_x, want.ha[0]);
				if (field_a_y !== want.ha[1]) report_mismatch("field_a_y", field_a_y, want.ha[1]);
				if (field_a_z !== want.ha[2]) report_mismatch("field_a_z", field_a_z, want.ha[2]);
				if (field_b_x !== want.hb[0]) report_mismatch("field_b_x", field_b_x, want.hb[0]);
				if (field_b_y !== want.hb[1]) report_mismatch("field_b_y", field_b_y, want.hb[1]);
				if (field_b_z !== want.hb[2]) report_mismatch("field_b_z", field_b_z, want.hb[2]);
				if (energy_a !== want.ea) report_mismatch("energy_a", energy_a, want.ea);
				if (energy_b !== want.eb) report_mismatch("energy_b", energy_b, want.eb);
				if (mean_energy !== want.mean)
					report_mismatch("mean_energy", mean_energy, want.mean);
				if (sweep_done !== want.done)
					report_mismatch("sweep_done", sweep_done, want.done);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Write one register; the predictor copy changes with it (block is idle)
	task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			REG_MESH_MODE:  cur_mode = value[0];
			REG_SAT_MAG:    cur_ms_pair = value;
			REG_ANIS_A:     cur_k_a = value;
			REG_ANIS_B:     cur_k_b = value;
			REG_AXIS_ONE:   cur_axis[0] = value[47:0];
			REG_AXIS_TWO:   cur_axis[1] = value[47:0];
			REG_AXIS_THREE: cur_axis[2] = value[47:0];
			default: ;
		endcase
	endtask

	task automatic write_all(logic mode, logic [63:0] ms, logic [63:0] ka, logic [63:0] kb,
			logic [47:0] e1, logic [47:0] e2, logic [47:0] e3);
		write_reg(REG_MESH_MODE, {63'd0, mode});
		write_reg(REG_SAT_MAG, ms);
		write_reg(REG_ANIS_A, ka);
		write_reg(REG_ANIS_B, kb);
		write_reg(REG_AXIS_ONE, {16'd0, e1});
		write_reg(REG_AXIS_TWO, {16'd0, e2});
		write_reg(REG_AXIS_THREE, {16'd0, e3});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every item has gone in and every result has come out, then let the
	// block settle before touching its registers
	task automatic wait_idle();
		while (pending_cells.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic logic signed [23:0] rand_comp(longint unsigned scale);
		longint s;
		s = scale > 64'd8388607 ? 8388607 : longint'(scale);
		if (s == 0 || $urandom_range(0, 9) < 3) return 24'($urandom());
		return 24'(longint'($urandom_range(0, 32'(2 * s))) - s);
	endfunction

	function automatic cell_item_t make_cell(logic signed [23:0] a, logic signed [23:0] b,
			logic empty, logic last);
		cell_item_t c;
		c.ma = '{a, -a, a};
		c.mb = '{b, b, -b};
		c.empty = empty;
		c.last = last;
		return c;
	endfunction

	// Extremes, empty cells, a sweep with no filled cell and ordinary sweeps
	task automatic push_directed();
		cell_item_t c;
		pending_cells.push_back(make_cell(24'sd0, 24'sd0, 1'b1, 1'b1));
		pending_cells.push_back(make_cell(24'sd8388607, 24'sd8388607, 1'b0, 1'b0));
		pending_cells.push_back(make_cell(-24'sd8388608, -24'sd8388608, 1'b0, 1'b0));
		pending_cells.push_back(make_cell(24'sd0, 24'sd0, 1'b0, 1'b0));
		pending_cells.push_back(make_cell(24'sd8388607, -24'sd8388608, 1'b1, 1'b0));
		pending_cells.push_back(make_cell(24'sd1, -24'sd1, 1'b0, 1'b1));
		c = make_cell(24'sd0, 24'sd0, 1'b0, 1'b0);
		c.ma[2] = 24'sd800000;
		c.mb[2] = -24'sd500000;
		pending_cells.push_back(c);
		c.ma = '{24'sd400000, 24'sd400000, 24'sd565685};
		c.mb = '{-24'sd300000, 24'sd250000, 24'sd300000};
		pending_cells.push_back(c);
		c.ma = '{24'sd565685, -24'sd565685, 24'sd0};
		c.last = 1'b1;
		pending_cells.push_back(c);
		pending_cells.push_back(make_cell(-24'sd8388608, 24'sd8388607, 1'b1, 1'b1));
	endtask

	// Random cells: mostly magnetization near Ms in size, some empty, sweeps of random length
	task automatic push_random(int count);
		cell_item_t c;
		longint unsigned sa, sb;
		sa = cur_ms_pair[31:0];
		sb = cur_ms_pair[63:32];
		for (int n = 0; n < count; n++) begin
			for (int i = 0; i < 3; i++) begin
				c.ma[i] = rand_comp(sa);
				c.mb[i] = rand_comp(sb);
			end
			c.empty = ($urandom_range(0, 9) == 0);
			c.last  = ($urandom_range(0, 15) == 0);
			pending_cells.push_back(c);
		end
	endtask

	function automatic logic [47:0] rand_axis();
		return 48'({$urandom(), $urandom()});
	endfunction

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_MESH_MODE;
		cfg_data     = '0;
		in_valid     = 1'b0;
		mag_a_x      = '0;
		mag_a_y      = '0;
		mag_a_z      = '0;
		mag_b_x      = '0;
		mag_b_y      = '0;
		mag_b_z      = '0;
		cell_empty   = 1'b0;
		last_cell    = 1'b0;
		out_stall    = 1'b0;
		cur_cell     = make_cell(24'sd0, 24'sd0, 1'b0, 1'b0);
		// Predictor starts from the reset values of the registers
		cur_mode     = 1'b0;
		cur_ms_pair  = 64'd3435973837600000;
		cur_k_a      = '0;
		cur_k_b      = '0;
		cur_axis[0]  = 48'd16384;
		cur_axis[1]  = 48'd1073741824;
		cur_axis[2]  = 48'd70368744177664;
		energy_sum   = 0;
		filled_cells = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: zero anisotropy constants
		push_directed();
		push_random(40);
		wait_idle();

		// Antiferromagnetic, realistic constants, tilted biaxial axes
		write_all(1'b1, {32'd500000, 32'd800000}, {-32'sd150000, 32'sd400000},
			{32'sd300000, -32'sd200000}, {16'sd0, 16'sd0, 16'sd16384},
			{16'sd0, 16'sd11585, 16'sd11585}, {16'sd0, 16'sd11585, -16'sd11585});
		push_directed();
		push_random(300);
		wait_idle();

		// Extremes: zero Ms on A, full Ms on B, constants at their bounds, axes at the ends of their range
		write_all(1'b1, {32'hFFFF_FFFF, 32'd0}, {32'h8000_0000, 32'h7FFF_FFFF},
			{32'h7FFF_FFFF, 32'h8000_0000}, {16'h8000, 16'h8000, 16'h8000},
			{16'h7FFF, 16'h8000, 16'h7FFF}, {16'h8000, 16'h7FFF, 16'h0000});
		push_directed();
		push_random(150);
		wait_idle();

		// Ferromagnetic, small Ms so projections clamp and fields saturate
		write_all(1'b0, {32'd77, 32'd1000}, {$urandom(), $urandom()},
			{$urandom(), $urandom()}, rand_axis(), rand_axis(), rand_axis());
		push_directed();
		push_random(250);
		wait_idle();

		// Fully random settings, several times over
		for (int k = 0; k < 3; k++) begin
			write_all(1'($urandom_range(0, 1)), {$urandom(), 32'($urandom_range(1, 1 << 20))},
				{$urandom(), $urandom()}, {$urandom(), $urandom()},
				rand_axis(), rand_axis(), rand_axis());
			push_random(180);
			wait_idle();
		end

		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
